### rtl/uft_pkg.sv
package uft_pkg;

  localparam int MaxNodes = 1024;
  localparam int NodeW    = $clog2(MaxNodes);
  localparam int SizeW    = NodeW + 1;
  localparam int CntW     = 16;
  localparam int WantW    = CntW + 1;

  // one entry of the node memory: parent pointer and set size
  typedef struct packed {
    logic [NodeW-1:0] parent;
    logic [SizeW-1:0] size;
  } node_word_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_WALK,
    S_CMPR,
    S_JOIN,
    S_LINK,
    S_GROW,
    S_HRD,
    S_HWR,
    S_SINIT,
    S_SRD,
    S_SACC,
    S_DONE
  } state_e;

endpackage

### rtl/union_find_top_components_unit.sv
// union-find engine with a top-components answer
//
// input channel: in_valid_i / in_ready_o carry one edge word (node_a_i, node_b_i).
// output channel: out_valid_o / out_ready_i carry one result word per edge:
// merged_o, redundant_total_o and best_sum_o.
// config: cfg_we_i writes cfg_node_count_i; the write also restarts the tables,
// so the user must do it only while the engine is idle; the block does not enforce it.
// state sits in two single-port-write memories: a node memory holding parent
// and size per node, and a histogram memory counting roots per set size.
// per edge: a root walk at one parent step per cycle, then a compression walk at the
// same rate, for each endpoint; on a join the merge update (link, grow and three
// histogram read-modify-writes); then a top-down histogram scan, a read and an
// accumulate per size level, which ends once enough sets are taken or at size one.
// one edge is in flight at a time; a finished result sits in the output
// register so the next edge is taken while the receiver stalls.
// after reset and after every config write the engine clears both memories,
// with in_ready_o low; results are held until taken.
module union_find_top_components_unit
  import uft_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SizeW-1:0] cfg_node_count_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [NodeW-1:0] node_a_i,
  input  logic [NodeW-1:0] node_b_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             merged_o,
  output logic [CntW-1:0]  redundant_total_o,
  output logic [NodeW-1:0] best_sum_o
);

  localparam int HistDepth = MaxNodes + 1;

  // memories
  node_word_t       node_mem [MaxNodes];
  logic [SizeW-1:0] hist_mem [HistDepth];

  state_e           state_q, state_d;
  logic [SizeW-1:0] n_q, n_d;
  logic [SizeW-1:0] n_eff;
  logic [SizeW-1:0] clr_q, clr_d;
  logic [CntW-1:0]  red_q, red_d;

  logic [NodeW-1:0] b_q, b_d;
  logic [NodeW-1:0] cur_q, cur_d;
  logic [NodeW-1:0] start_q, start_d;
  logic             side_q, side_d;
  logic [NodeW-1:0] ra_q, ra_d, rb_q, rb_d;
  logic [SizeW-1:0] sa_q, sa_d, sb_q, sb_d;
  logic             merged_q, merged_d;
  logic [1:0]       hstep_q, hstep_d;

  logic [SizeW-1:0] s_q, s_d;
  logic [WantW-1:0] taken_q, taken_d;
  logic [WantW-1:0] want;
  logic [NodeW-1:0] sum_q, sum_d;

  // memory ports
  logic [NodeW-1:0] nrd_addr;
  node_word_t       nrd_q;
  logic             nwe;
  logic [NodeW-1:0] nwa;
  node_word_t       nwd;
  logic [SizeW-1:0] hrd_addr;
  logic [SizeW-1:0] hrd_q;
  logic             hwe;
  logic [SizeW-1:0] hwa;
  logic [SizeW-1:0] hwd;
  logic [SizeW-1:0] haddr_step;

  // output register
  logic             out_valid_q, out_valid_d;
  logic             out_merged_q, out_merged_d;
  logic [CntW-1:0]  out_red_q, out_red_d;
  logic [NodeW-1:0] out_sum_q, out_sum_d;

  logic             in_acc;
  logic             a_ok, b_ok;
  logic [WantW-1:0] remain;
  logic [WantW-1:0] take;
  logic [2*SizeW-1:0] prod;

  always_comb begin
    if (n_q == '0) begin
      n_eff = SizeW'(1);
    end else if (n_q > SizeW'(MaxNodes)) begin
      n_eff = SizeW'(MaxNodes);
    end else begin
      n_eff = n_q;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign a_ok       = {1'b0, node_a_i} < n_eff;
  assign b_ok       = {1'b0, node_b_i} < n_eff;
  assign want       = {1'b0, red_q} + WantW'(1);
  assign remain     = want - taken_q;
  assign take       = ({6'd0, hrd_q} < remain) ? {6'd0, hrd_q} : remain;
  assign prod       = take[SizeW-1:0] * s_q;

  // histogram address for the three merge updates: old sizes out, new size in
  always_comb begin
    case (hstep_q)
      2'd0:    haddr_step = sa_q;
      2'd1:    haddr_step = sb_q;
      default: haddr_step = sa_q + sb_q;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    n_d          = n_q;
    clr_d        = clr_q;
    red_d        = red_q;
    b_d          = b_q;
    cur_d        = cur_q;
    start_d      = start_q;
    side_d       = side_q;
    ra_d         = ra_q;
    rb_d         = rb_q;
    sa_d         = sa_q;
    sb_d         = sb_q;
    merged_d     = merged_q;
    hstep_d      = hstep_q;
    s_d          = s_q;
    taken_d      = taken_q;
    sum_d        = sum_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_merged_d = out_merged_q;
    out_red_d    = out_red_q;
    out_sum_d    = out_sum_q;
    nrd_addr     = cur_q;
    nwe          = 1'b0;
    nwa          = cur_q;
    nwd          = nrd_q;
    hrd_addr     = haddr_step;
    hwe          = 1'b0;
    hwa          = haddr_step;
    hwd          = hrd_q;

    case (state_q)
      S_CLR: begin
        nwe = (clr_q < SizeW'(MaxNodes));
        nwa = clr_q[NodeW-1:0];
        nwd = '{parent: clr_q[NodeW-1:0], size: SizeW'(1)};
        hwe = 1'b1;
        hwa = clr_q;
        hwd = (clr_q == SizeW'(1)) ? n_eff : '0;
        clr_d = clr_q + SizeW'(1);
        if (clr_q == SizeW'(MaxNodes)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        merged_d = 1'b0;
        if (in_acc) begin
          b_d      = node_b_i;
          cur_d    = node_a_i;
          start_d  = node_a_i;
          nrd_addr = node_a_i;
          side_d   = 1'b0;
          state_d  = (a_ok && b_ok) ? S_WALK : S_SINIT;
        end
      end
      // find the root, one parent step per cycle
      S_WALK: begin
        if (nrd_q.parent == cur_q) begin
          if (side_q) begin
            rb_d = cur_q;
            sb_d = nrd_q.size;
          end else begin
            ra_d = cur_q;
            sa_d = nrd_q.size;
          end
          cur_d    = start_q;
          nrd_addr = start_q;
          state_d  = S_CMPR;
        end else begin
          cur_d    = nrd_q.parent;
          nrd_addr = nrd_q.parent;
        end
      end
      // walk the path again, pointing each node at the root
      S_CMPR: begin
        if (nrd_q.parent == cur_q) begin
          if (side_q) begin
            state_d = S_JOIN;
          end else begin
            side_d   = 1'b1;
            cur_d    = b_q;
            start_d  = b_q;
            nrd_addr = b_q;
            state_d  = S_WALK;
          end
        end else begin
          nwe      = 1'b1;
          nwa      = cur_q;
          nwd      = '{parent: (side_q ? rb_q : ra_q), size: nrd_q.size};
          cur_d    = nrd_q.parent;
          nrd_addr = nrd_q.parent;
        end
      end
      S_JOIN: begin
        if (ra_q == rb_q) begin
          if (red_q != '1) begin
            red_d = red_q + CntW'(1);
          end
          state_d = S_SINIT;
        end else begin
          merged_d = 1'b1;
          if (sa_q < sb_q) begin
            ra_d = rb_q;
            rb_d = ra_q;
            sa_d = sb_q;
            sb_d = sa_q;
          end
          state_d = S_LINK;
        end
      end
      S_LINK: begin
        nwe     = 1'b1;
        nwa     = rb_q;
        nwd     = '{parent: ra_q, size: sb_q};
        state_d = S_GROW;
      end
      S_GROW: begin
        nwe     = 1'b1;
        nwa     = ra_q;
        nwd     = '{parent: ra_q, size: sa_q + sb_q};
        hstep_d = 2'd0;
        state_d = S_HRD;
      end
      S_HRD: begin
        state_d = S_HWR;
      end
      S_HWR: begin
        hwe = 1'b1;
        hwd = (hstep_q == 2'd2) ? hrd_q + SizeW'(1) : hrd_q - SizeW'(1);
        hstep_d = hstep_q + 2'd1;
        state_d = (hstep_q == 2'd2) ? S_SINIT : S_HRD;
      end
      S_SINIT: begin
        s_d     = SizeW'(MaxNodes);
        taken_d = '0;
        sum_d   = '0;
        state_d = S_SRD;
      end
      S_SRD: begin
        hrd_addr = s_q;
        state_d  = S_SACC;
      end
      // take as many sets of this size as still wanted
      S_SACC: begin
        taken_d = taken_q + take;
        sum_d   = sum_q + prod[NodeW-1:0];
        s_d     = s_q - SizeW'(1);
        if ((taken_q + take) >= want || s_q == SizeW'(1)) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SRD;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_merged_d = merged_q;
          out_red_d    = red_q;
          out_sum_d    = sum_q - NodeW'(1);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      n_d     = cfg_node_count_i;
      clr_d   = '0;
      red_d   = '0;
      state_d = S_CLR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      n_q         <= SizeW'(MaxNodes);
      clr_q       <= '0;
      red_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      clr_q       <= clr_d;
      red_q       <= red_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q          <= b_d;
    cur_q        <= cur_d;
    start_q      <= start_d;
    side_q       <= side_d;
    ra_q         <= ra_d;
    rb_q         <= rb_d;
    sa_q         <= sa_d;
    sb_q         <= sb_d;
    merged_q     <= merged_d;
    hstep_q      <= hstep_d;
    s_q          <= s_d;
    taken_q      <= taken_d;
    sum_q        <= sum_d;
    out_merged_q <= out_merged_d;
    out_red_q    <= out_red_d;
    out_sum_q    <= out_sum_d;
  end

  // node memory
  always_ff @(posedge clk_i) begin
    if (nwe) begin
      node_mem[nwa] <= nwd;
    end
    nrd_q <= node_mem[nrd_addr];
  end

  // size histogram memory
  always_ff @(posedge clk_i) begin
    if (hwe) begin
      hist_mem[hwa] <= hwd;
    end
    hrd_q <= hist_mem[hrd_addr];
  end

  assign out_valid_o       = out_valid_q;
  assign merged_o          = out_merged_q;
  assign redundant_total_o = out_red_q;
  assign best_sum_o        = out_sum_q;

  // checks
  a_clr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLR |-> clr_q <= SizeW'(MaxNodes))
    else $error("clear counter past end of memory");

  a_taken_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SACC |=> taken_q <= want || cfg_we_i || $past(cfg_we_i))
    else $error("scan took more sets than wanted");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !cfg_we_i |=> state_q != S_IDLE)
    else $error("edge accepted but engine stayed idle");

  a_red_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_q == '1 && !cfg_we_i |=> red_q == '1)
    else $error("redundant counter wrapped");

endmodule

### tb/sv/tb_union_find_top_components_unit.sv
`timescale 1ns / 1ps

module tb_union_find_top_components_unit;
  import uft_pkg::*;

  // edge result as the engine reports it
  typedef struct {
    logic             merged;
    logic [CntW-1:0]  redundant;
    logic [NodeW-1:0] best;
  } dsu_result_t;

  // one row of the directed table: either a node count write or an edge
  typedef struct {
    bit               is_cfg;
    logic [SizeW-1:0] count;
    logic [NodeW-1:0] a;
    logic [NodeW-1:0] b;
    bit               typed;
    dsu_result_t      res;
  } edge_row_t;

  localparam int DrainCycles = 2200;  // longest histogram scan plus margin
  localparam int DogLimit    = 20000; // clearing pass, full scan and stalls, several times over

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [SizeW-1:0] cfg_node_count_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [NodeW-1:0] node_a_i = '0;
  logic [NodeW-1:0] node_b_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic             merged_o;
  logic [CntW-1:0]  redundant_total_o;
  logic [NodeW-1:0] best_sum_o;

  union_find_top_components_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_node_count_i (cfg_node_count_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .node_a_i         (node_a_i),
    .node_b_i         (node_b_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .merged_o         (merged_o),
    .redundant_total_o(redundant_total_o),
    .best_sum_o       (best_sum_o)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the disjoint-set state
  int          shadow_parent [MaxNodes];
  int          shadow_size   [MaxNodes];
  int          shadow_redund;
  int          shadow_count;
  dsu_result_t pending_results [$];

  int  errors;
  int  edges_sent;
  int  results_seen;
  int  cfg_writes;
  int  merges_seen;
  int  redund_edges;
  bit  quiet;          // no idling on either side while set
  int  dog;

  // restore the shadow tables, as any node count write does
  function automatic void shadow_clear(int count);
    for (int i = 0; i < MaxNodes; i++) begin
      shadow_parent[i] = i;
      shadow_size[i]   = 1;
    end
    shadow_redund = 0;
    if (count == 0) shadow_count = 1;
    else if (count > MaxNodes) shadow_count = MaxNodes;
    else shadow_count = count;
  endfunction

  // root walk, then point every node on the path straight at the root
  function automatic int root_of(int x);
    int r;
    int nxt;
    r = x;
    while (shadow_parent[r] != r) r = shadow_parent[r];
    while (shadow_parent[x] != x) begin
      nxt = shadow_parent[x];
      shadow_parent[x] = r;
      x = nxt;
    end
    return r;
  endfunction

  // sizes of the largest redundant+1 components, summed, minus one
  function automatic int top_components_sum();
    int hist [MaxNodes+1];
    int want;
    int taken;
    int sum;
    int c;
    for (int s = 0; s <= MaxNodes; s++) hist[s] = 0;
    for (int i = 0; i < shadow_count; i++)
      if (shadow_parent[i] == i) hist[shadow_size[i]]++;
    want  = shadow_redund + 1;
    taken = 0;
    sum   = 0;
    for (int s = MaxNodes; s >= 1 && taken < want; s--) begin
      c = hist[s];
      if (c > want - taken) c = want - taken;
      taken += c;
      sum += c * s;
    end
    return sum - 1;
  endfunction

  function automatic dsu_result_t apply_edge(int a, int b);
    dsu_result_t r;
    int ra;
    int rb;
    int t;
    r.merged = 1'b0;
    if (a < shadow_count && b < shadow_count) begin
      ra = root_of(a);
      rb = root_of(b);
      if (ra != rb) begin
        if (shadow_size[ra] < shadow_size[rb]) begin
          t = ra; ra = rb; rb = t;
        end
        shadow_parent[rb] = ra;
        shadow_size[ra] += shadow_size[rb];
        r.merged = 1'b1;
      end else if (shadow_redund < 65535) begin
        shadow_redund++;
      end
    end
    r.redundant = shadow_redund[CntW-1:0];
    r.best      = NodeW'(top_components_sum());
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int exp);
    errors++;
    $display("mismatch on result %0d: %s got %0d expected %0d", results_seen, field, got, exp);
  endtask

  // offer one edge word; returns at the edge where it is taken
  task automatic send_edge(int a, int b, bit typed, dsu_result_t typed_res);
    dsu_result_t pred;
    if (!quiet && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 19);
    end
    in_valid_i <= 1'b1;
    node_a_i   <= a[NodeW-1:0];
    node_b_i   <= b[NodeW-1:0];
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    // predictor still steps on typed rows so its state stays in line
    pred = apply_edge(a, b);
    pending_results.push_back(typed ? typed_res : pred);
    edges_sent++;
  endtask

  // stop offering, let every result come home, then cover the scan latency
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_count(int count);
    drain();
    cfg_we_i         <= 1'b1;
    cfg_node_count_i <= count[SizeW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_clear(count);
    cfg_writes++;
  endtask

  // random edges: mostly inside the node range, a few beyond it when the count is below the maximum
  task automatic random_phase(int count, int items);
    int n;
    int span;
    int a;
    int b;
    dsu_result_t unused;
    unused = '{default: '0};
    n = (count == 0) ? 1 : (count > MaxNodes ? MaxNodes : count);
    for (int i = 0; i < items; i++) begin
      if (n >= MaxNodes || $urandom_range(99) < 10) begin
        a = $urandom_range(MaxNodes-1);
        b = $urandom_range(MaxNodes-1);
      end else begin
        span = (n + 3 > MaxNodes) ? MaxNodes - 1 : n + 2;
        a = ($urandom_range(99) < 90) ? $urandom_range(n-1) : $urandom_range(span);
        b = ($urandom_range(99) < 15) ? a : $urandom_range(n-1);
      end
      send_edge(a, b, 1'b0, unused);
    end
  endtask

  // receive side: random back-pressure and in-order comparison
  always @(posedge clk_i) begin
    dsu_result_t exp;
    if (out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("result word with nothing pending");
      end else begin
        exp = pending_results.pop_front();
        if (merged_o !== exp.merged) report_mismatch("merged", merged_o, exp.merged);
        if (redundant_total_o !== exp.redundant)
          report_mismatch("redundant_total", redundant_total_o, exp.redundant);
        if (best_sum_o !== exp.best) report_mismatch("best_sum", best_sum_o, exp.best);
        if (merged_o) merges_seen++;
        else redund_edges++;
      end
      results_seen++;
    end
    out_ready_i <= quiet || ($urandom_range(99) >= 19);
  end

  // watchdog: cycles with no word moved on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) dog <= 0;
    else dog <= dog + 1;
    if (dog >= DogLimit) begin
      $display("watchdog expired after %0d idle cycles", dog);
      $display("Simulation FAILED");
      $finish;
    end
  end

  edge_row_t rows [] = '{
    // default count after reset: first join, self edge, repeat of a joined pair
    '{0, 0,    0,    1, 1, '{1'b1, 16'd0, 10'd1}},
    '{0, 0, 1023, 1023, 1, '{1'b0, 16'd1, 10'd2}},
    '{0, 0,    1,    0, 1, '{1'b0, 16'd2, 10'd3}},
    '{0, 0, 1023,    0, 0, '{default: '0}},
    '{0, 0,  512,  511, 0, '{default: '0}},
    '{0, 0,  682,  341, 0, '{default: '0}},
    // zero count behaves as one node
    '{1, 0,    0,    0, 0, '{default: '0}},
    '{0, 0,    0,    0, 1, '{1'b0, 16'd1, 10'd0}},
    '{0, 0,    1,    0, 1, '{1'b0, 16'd1, 10'd0}},
    '{0, 0, 1023, 1023, 1, '{1'b0, 16'd1, 10'd0}},
    // three nodes: endpoints beyond the range are ignored
    '{1, 3,    0,    0, 0, '{default: '0}},
    '{0, 0,    2,    3, 1, '{1'b0, 16'd0, 10'd0}},
    '{0, 0, 1023,    0, 1, '{1'b0, 16'd0, 10'd0}},
    '{0, 0,    0,    1, 0, '{default: '0}},
    '{0, 0,    1,    2, 0, '{default: '0}},
    '{0, 0,    2,    0, 1, '{1'b0, 16'd1, 10'd2}},
    // count above the maximum clamps to the maximum
    '{1, 2047, 0,    0, 0, '{default: '0}},
    '{0, 0, 1023,    0, 1, '{1'b1, 16'd0, 10'd1}},
    '{0, 0,    5,    6, 0, '{default: '0}},
    '{0, 0,    6, 1023, 0, '{default: '0}},
    '{0, 0,    5,    0, 0, '{default: '0}}
  };

  initial begin
    errors = 0; edges_sent = 0; results_seen = 0; cfg_writes = 0;
    merges_seen = 0; redund_edges = 0; quiet = 1'b0; dog = 0;
    shadow_clear(MaxNodes);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_count(rows[i].count);
      else send_edge(rows[i].a, rows[i].b, rows[i].typed, rows[i].res);
    end

    // random phases across several node counts
    random_phase(MaxNodes, 15);
    write_count(16);
    random_phase(16, 12);
    quiet = 1'b1;                 // long stretch with no idling on either side
    random_phase(16, 15);
    quiet = 1'b0;
    drain();                      // sender holds off until every result is home
    random_phase(16, 10);
    write_count(1);
    random_phase(1, 6);
    write_count(5);
    random_phase(5, 15);
    write_count(1024);
    random_phase(1024, 12);
    write_count(40);
    random_phase(40, 15);

    drain();
    $display("edges sent %0d, results checked %0d, node count writes %0d",
             edges_sent, results_seen, cfg_writes);
    $display("joins %0d, other edges %0d, counts from one to the maximum, clamps included",
             merges_seen, redund_edges);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
